@@ src/descriptor_slot_allocator_assert.svh @@
// ----------------------------------------------------------------------------
// Descriptor slot allocator assertion macros
// Concurrent assertion wrappers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef DESCRIPTOR_SLOT_ALLOCATOR_ASSERT_SVH
`define DESCRIPTOR_SLOT_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising clock edge out of reset.
`define DSA_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define DSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define DSA_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define DSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ src/dsa_pkg.sv @@
// ----------------------------------------------------------------------------
// Descriptor slot allocator package
// Field widths, action and status codes, and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package dsa_pkg;

	// Default table size and the first slot that may be handed out.
	localparam int TABLE_SIZE_DEF = 256;
	localparam int FIRST_SLOT     = 2;

	// Field widths.
	localparam int ACTION_W = 2;
	localparam int SLOT_W   = 8;
	localparam int HANDLE_W = 32;
	localparam int STATUS_W = 2;
	localparam int TDATA_W  = 40;

	// Action codes.
	localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_GET   = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_CLOSE = 2'd2;

	// Status codes.
	localparam logic [STATUS_W-1:0] STS_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STS_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] STS_BAD  = 2'd2;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SCAN_ADD,
		ST_SCAN_NEXT,
		ST_DONE
	} dsa_state_t;

endpackage

`default_nettype wire

@@ src/descriptor_slot_allocator.sv @@
// ----------------------------------------------------------------------------
// Descriptor slot allocator
// Round-robin free-slot allocator over a table of object handles, with add,
// get and close requests and one response per request.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tuser: action; tdata: slot, handle
// m_*       out  m_tvalid/m_tready  tuser: status; tdata: slot_out, handle_out
//
// Get and close go from decode straight to the done state, where the response
// is loaded into the output register once that is free. An add scans the
// occupancy bits with one shared compare and wrap unit, one slot per cycle:
// once to find the slot and once more to place the pointer, each scan at most
// TABLE_SIZE-2 slots (capped 254); the second scan is skipped when the table
// is full. The block takes one request at a time; s_tready is high only when
// idle. The response sits in an output register, so a new request is accepted
// while it waits. arst_n clears the occupancy bits at once, no sweep needed.
//
`default_nettype none

`include "descriptor_slot_allocator_assert.svh"

module descriptor_slot_allocator #(
	parameter int TABLE_SIZE = dsa_pkg::TABLE_SIZE_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output      logic                          s_tready,
	// [7:0] slot, [39:8] handle
	input  wire logic [dsa_pkg::TDATA_W-1:0]   s_tdata,
	// [1:0] action
	input  wire logic [dsa_pkg::ACTION_W-1:0]  s_tuser,
	output      logic                          m_tvalid,
	input  wire logic                          m_tready,
	// [7:0] slot_out, [39:8] handle_out
	output      logic [dsa_pkg::TDATA_W-1:0]   m_tdata,
	// [1:0] status
	output      logic [dsa_pkg::STATUS_W-1:0]  m_tuser
);
	import dsa_pkg::*;

	localparam int USABLE = (TABLE_SIZE < 256) ? TABLE_SIZE : 256;
	localparam int IW     = $clog2(USABLE);
	localparam logic [IW-1:0] FIRST_IDX = IW'(FIRST_SLOT);
	localparam logic [IW-1:0] LAST_IDX  = IW'(USABLE - 1);
	localparam logic [IW-1:0] SCAN_LAST = IW'(USABLE - 3);

	dsa_state_t state_q, state_d;

	logic [ACTION_W-1:0] action_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [IW-1:0]       ptr_q;
	logic [IW-1:0]       scan_q;
	logic [IW-1:0]       cnt_q;
	logic [IW-1:0]       got_q;
	logic                full_q;
	logic [USABLE-1:0]   occ_q;
	logic [HANDLE_W-1:0] mem [USABLE];
	logic [HANDLE_W-1:0] rd_data_q;
	logic                m_tvalid_q;
	logic [TDATA_W-1:0]  m_tdata_q;
	logic [STATUS_W-1:0] m_tuser_q;

	logic                slot_ok;
	logic [IW-1:0]       slot_idx;
	logic                scan_free;
	logic                scan_end;
	logic [IW-1:0]       scan_wrap;
	logic [IW-1:0]       got_wrap;
	logic                out_free;

	logic                in_ready;
	logic                start_scan;
	logic                take_slot;
	logic                mark_full;
	logic                set_ptr_found;
	logic                set_ptr_wrap;
	logic                do_close;
	logic                load_out;

	logic [SLOT_W-1:0]   res_slot;
	logic [HANDLE_W-1:0] res_handle;
	logic [STATUS_W-1:0] res_status;

	// Shared scan unit: range check, occupancy test and wrap increment.
	assign slot_ok   = (slot_q >= SLOT_W'(FIRST_SLOT)) && ({1'b0, slot_q} < 9'(USABLE));
	assign slot_idx  = slot_q[IW-1:0];
	assign scan_free = !occ_q[scan_q];
	assign scan_end  = (cnt_q == SCAN_LAST);
	assign scan_wrap = (scan_q == LAST_IDX) ? FIRST_IDX : scan_q + 1'b1;
	assign got_wrap  = (got_q == LAST_IDX) ? FIRST_IDX : got_q + 1'b1;
	assign out_free  = !m_tvalid_q || m_tready;

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				state_d = (action_q == ACT_ADD) ? ST_SCAN_ADD : ST_DONE;
			end
			ST_SCAN_ADD: begin
				if (scan_free) state_d = ST_SCAN_NEXT;
				else if (scan_end) state_d = ST_DONE;
			end
			ST_SCAN_NEXT: begin
				if (scan_free || scan_end) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer strobes.
	always_comb begin
		in_ready      = 1'b0;
		start_scan    = 1'b0;
		take_slot     = 1'b0;
		mark_full     = 1'b0;
		set_ptr_found = 1'b0;
		set_ptr_wrap  = 1'b0;
		do_close      = 1'b0;
		load_out      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_DECODE: begin
				start_scan = 1'b1;
				do_close   = (action_q == ACT_CLOSE) && slot_ok;
			end
			ST_SCAN_ADD: begin
				take_slot = scan_free;
				mark_full = !scan_free && scan_end;
			end
			ST_SCAN_NEXT: begin
				set_ptr_found = scan_free;
				set_ptr_wrap  = !scan_free && scan_end;
			end
			ST_DONE: begin
				load_out = out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// Response fields for the request in hand.
	always_comb begin
		res_slot   = slot_q;
		res_handle = '0;
		res_status = STS_OK;
		case (action_q)
			ACT_ADD: begin
				if (full_q) begin
					res_slot   = '0;
					res_status = STS_FULL;
				end else begin
					res_slot = SLOT_W'(got_q);
				end
			end
			ACT_GET: begin
				if (slot_ok) res_handle = occ_q[slot_idx] ? rd_data_q : '0;
				else res_status = STS_BAD;
			end
			ACT_CLOSE: begin
				if (!slot_ok) res_status = STS_BAD;
			end
			default: res_status = STS_BAD;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ptr_q      <= FIRST_IDX;
			full_q     <= 1'b0;
			occ_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start_scan) full_q <= 1'b0;
			else if (mark_full) full_q <= 1'b1;
			if (set_ptr_found) ptr_q <= scan_q;
			else if (set_ptr_wrap) ptr_q <= got_wrap;
			if (take_slot && (handle_q != '0)) occ_q[scan_q] <= 1'b1;
			if (do_close) occ_q[slot_idx] <= 1'b0;
			if (load_out) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	// Request capture, scan position and response payload.
	always_ff @(posedge clk) begin
		if (in_ready && s_tvalid) begin
			action_q <= s_tuser;
			slot_q   <= s_tdata[SLOT_W-1:0];
			handle_q <= s_tdata[SLOT_W +: HANDLE_W];
		end
		if (start_scan) begin
			scan_q <= ptr_q;
			cnt_q  <= '0;
		end else if (take_slot) begin
			got_q  <= scan_q;
			scan_q <= scan_wrap;
			cnt_q  <= '0;
		end else begin
			scan_q <= scan_wrap;
			cnt_q  <= cnt_q + 1'b1;
		end
		if (load_out) begin
			m_tdata_q <= {res_handle, res_slot};
			m_tuser_q <= res_status;
		end
	end

	// Handle store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (take_slot) mem[scan_q] <= handle_q;
		rd_data_q <= mem[slot_idx];
	end

	assign s_tready = in_ready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// Checks on the allocator's own logic.
	`DSA_ASSERT_IMPLY(a_full_slot_zero, clk, arst_n, m_tvalid && (m_tuser == STS_FULL), m_tdata[SLOT_W-1:0] == '0, "full table response carries a nonzero slot")
	`DSA_ASSERT_IMPLY(a_ptr_range, clk, arst_n, 1'b1, (ptr_q >= FIRST_IDX) && (ptr_q <= LAST_IDX), "next-free pointer left the usable range")
	`DSA_ASSERT_NEXT(a_take_marks, clk, arst_n, take_slot && (handle_q != '0), occ_q[got_q], "allocated slot not marked occupied")
	`DSA_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready, "second transaction accepted while busy")

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Descriptor slot allocator testbench
// Sends add, get and close requests over the input stream and checks every
// response against a built-in prediction of the slot table and its rotating
// search pointer. Both streams stall at random. The run covers a full table,
// reserved slots, invalid actions and wrap-around of the pointer.
// ----------------------------------------------------------------------------

module testbench;

	import dsa_pkg::*;

	// Table geometry as the block sees it.
	localparam int TBL_SIZE = TABLE_SIZE_DEF;
	localparam int USABLE   = (TBL_SIZE < 256) ? TBL_SIZE : 256;
	localparam int NO_SLOT  = 0;

	// Action code that the block must reject.
	localparam logic [ACTION_W-1:0] ACT_INVALID = 2'd3;

	// Run bounds: an add scans at most twice the usable slots.
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int DRAIN_CYCLES = 2 * USABLE + 100;
	localparam int IDLE_PCT = 38;

	typedef struct {
		logic [ACTION_W-1:0] action;
		logic [SLOT_W-1:0]   slot;
		logic [HANDLE_W-1:0] handle;
	} request_t;

	typedef struct {
		logic [SLOT_W-1:0]   slot_out;
		logic [HANDLE_W-1:0] handle_out;
		logic [STATUS_W-1:0] status;
	} response_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [TDATA_W-1:0]  s_tdata = '0;
	logic [ACTION_W-1:0] s_tuser = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [TDATA_W-1:0]  m_tdata;
	logic [STATUS_W-1:0] m_tuser;

	// Requests waiting to be sent and responses waiting to arrive.
	request_t  pending_requests[$];
	response_t expected_responses[$];
	request_t  current_request;

	// Predicted allocator state.
	logic [HANDLE_W-1:0] slot_handles[USABLE];
	logic [SLOT_W-1:0]   search_ptr;

	int  sent_count = 0;
	int  mismatches = 0;
	int  cycle_count = 0;
	logic calm;

	descriptor_slot_allocator #(.TABLE_SIZE(TBL_SIZE)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// A stretch of transactions in the middle runs without any stalls.
	assign calm = (sent_count >= 250) && (sent_count < 400);

	// Slot after s in the cycle of usable slots.
	function automatic int wrap_slot(int s);
		int n;
		n = s + 1;
		if (n >= USABLE || n < FIRST_SLOT)
			n = FIRST_SLOT;
		return n;
	endfunction

	// First empty slot over one full cycle from start, or NO_SLOT.
	function automatic int first_empty_from(int start);
		int s;
		s = start;
		for (int i = 0; i < USABLE - FIRST_SLOT; i++) begin
			if (slot_handles[s] == '0)
				return s;
			s = wrap_slot(s);
		end
		return NO_SLOT;
	endfunction

	// Applies one request to the predicted table and returns its response.
	function automatic response_t predict_response(request_t r);
		response_t o;
		int start;
		int got;
		int nx;
		bit slot_ok;
		o.slot_out = r.slot;
		o.handle_out = '0;
		o.status = STS_OK;
		slot_ok = (r.slot >= FIRST_SLOT) && (r.slot < USABLE);
		case (r.action)
			ACT_ADD: begin
				start = search_ptr;
				if (start < FIRST_SLOT || start >= USABLE)
					start = FIRST_SLOT;
				got = first_empty_from(start);
				if (got == NO_SLOT) begin
					o.status = STS_FULL;
					o.slot_out = '0;
				end else begin
					slot_handles[got] = r.handle;
					nx = first_empty_from(wrap_slot(got));
					search_ptr = SLOT_W'((nx != NO_SLOT) ? nx : wrap_slot(got));
					o.slot_out = SLOT_W'(got);
				end
			end
			ACT_GET: begin
				if (slot_ok)
					o.handle_out = slot_handles[r.slot];
				else
					o.status = STS_BAD;
			end
			ACT_CLOSE: begin
				if (slot_ok)
					slot_handles[r.slot] = '0;
				else
					o.status = STS_BAD;
			end
			default: begin
				o.status = STS_BAD;
			end
		endcase
		return o;
	endfunction

	task automatic push_request(logic [ACTION_W-1:0] a, int s, logic [HANDLE_W-1:0] h);
		request_t r;
		r.action = a;
		r.slot = s[SLOT_W-1:0];
		r.handle = h;
		pending_requests.push_back(r);
	endtask

	// Random handle with the extremes and the empty value mixed in.
	function automatic logic [HANDLE_W-1:0] random_handle();
		int pick;
		pick = $urandom_range(19);
		if (pick == 0)
			return '0;
		if (pick == 1)
			return '1;
		if (pick == 2)
			return 32'd1;
		return $urandom;
	endfunction

	// Nonzero handle, so that an add really occupies its slot.
	function automatic logic [HANDLE_W-1:0] live_handle();
		logic [HANDLE_W-1:0] h;
		h = $urandom;
		return (h == '0) ? 32'hFFFF_FFFF : h;
	endfunction

	// Random slot, leaning on the reserved slots and the top of the table.
	function automatic int random_slot();
		int pick;
		pick = $urandom_range(9);
		if (pick == 0)
			return $urandom_range(FIRST_SLOT - 1);
		if (pick == 1)
			return USABLE - 1;
		return $urandom_range(255);
	endfunction

	// Driver: presents queued requests and records the prediction of each
	// accepted transaction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_responses.push_back(predict_response(current_request));
				sent_count <= sent_count + 1;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_requests.size() > 0 &&
						(calm || $urandom_range(99) >= IDLE_PCT)) begin
					current_request = pending_requests.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {current_request.handle, current_request.slot};
					s_tuser <= current_request.action;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	task automatic report_mismatch(string what, logic [HANDLE_W-1:0] want,
			logic [HANDLE_W-1:0] seen);
		if (mismatches < 10)
			$display("mismatch at cycle %0d: %s expected 0x%0h, got 0x%0h",
				cycle_count, what, want, seen);
		mismatches++;
	endtask

	// Monitor: checks each response transaction against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_responses.size() == 0) begin
					report_mismatch("unexpected response, slot_out", '0,
						HANDLE_W'(m_tdata[7:0]));
				end else begin
					if (m_tdata[7:0] !== expected_responses[0].slot_out)
						report_mismatch("slot_out",
							HANDLE_W'(expected_responses[0].slot_out),
							HANDLE_W'(m_tdata[7:0]));
					if (m_tdata[39:8] !== expected_responses[0].handle_out)
						report_mismatch("handle_out", expected_responses[0].handle_out,
							m_tdata[39:8]);
					if (m_tuser !== expected_responses[0].status)
						report_mismatch("status", HANDLE_W'(expected_responses[0].status),
							HANDLE_W'(m_tuser));
					void'(expected_responses.pop_front());
				end
			end
			m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		int k;
		int base;
		int kind;
		int random_start;
		int total_requests;

		for (int i = 0; i < USABLE; i++)
			slot_handles[i] = '0;
		search_ptr = SLOT_W'(FIRST_SLOT);

		// Directed part: extremes, reserved slots, empty handle, bad action.
		push_request(ACT_ADD, 0, 32'h1234_5678);
		push_request(ACT_ADD, 255, 32'hFFFF_FFFF);
		push_request(ACT_ADD, 0, 32'h0000_0000);
		push_request(ACT_ADD, 170, 32'h0000_0001);
		push_request(ACT_GET, 2, '0);
		push_request(ACT_GET, 3, '1);
		push_request(ACT_GET, 4, '0);
		push_request(ACT_GET, 5, '0);
		push_request(ACT_GET, 0, '0);
		push_request(ACT_GET, 1, '0);
		push_request(ACT_CLOSE, 0, '0);
		push_request(ACT_CLOSE, 1, '1);
		push_request(ACT_GET, USABLE - 1, '0);
		push_request(ACT_CLOSE, USABLE - 1, '0);
		push_request(ACT_CLOSE, 3, '0);
		push_request(ACT_GET, 3, '0);
		push_request(ACT_ADD, 85, 32'hA5A5_A5A5);
		push_request(ACT_INVALID, 8'hAA, 32'h5555_5555);
		push_request(ACT_INVALID, 255, 32'hAAAA_AAAA);
		push_request(ACT_INVALID, 0, '0);
		push_request(ACT_CLOSE, 2, '0);
		push_request(ACT_ADD, 0, 32'h8000_0000);
		push_request(ACT_GET, 2, '0);

		// Random part: mixed traffic, then a fill past full, then episodes of mixed
		// traffic, add and get bursts, and runs that free slots and hand them out again.
		random_start = pending_requests.size();
		for (int e = 0; e < 5; e++) begin
			for (int j = 0; j < 20; j++) begin
				kind = $urandom_range(99);
				if (kind < 35)
					push_request(ACT_ADD, $urandom_range(255), random_handle());
				else if (kind < 65)
					push_request(ACT_GET, random_slot(), $urandom);
				else if (kind < 90)
					push_request(ACT_CLOSE, random_slot(), $urandom);
				else
					push_request(ACT_INVALID, $urandom_range(255), $urandom);
			end
		end
		for (int j = 0; j < USABLE + 6; j++)
			push_request(ACT_ADD, $urandom_range(255), live_handle());
		while (pending_requests.size() - random_start < 600) begin
			kind = $urandom_range(3);
			case (kind)
				0: begin
					for (int j = 0; j < 20; j++) begin
						k = $urandom_range(99);
						if (k < 35)
							push_request(ACT_ADD, $urandom_range(255), random_handle());
						else if (k < 65)
							push_request(ACT_GET, random_slot(), $urandom);
						else if (k < 90)
							push_request(ACT_CLOSE, random_slot(), $urandom);
						else
							push_request(ACT_INVALID, $urandom_range(255), $urandom);
					end
				end
				1: begin
					k = $urandom_range(1, 8);
					base = $urandom_range(FIRST_SLOT, USABLE - k);
					for (int j = 0; j < k; j++)
						push_request(ACT_CLOSE, base + j, $urandom);
					for (int j = 0; j < k + 1; j++)
						push_request(ACT_ADD, $urandom_range(255), live_handle());
					for (int j = 0; j < k; j++)
						push_request(ACT_GET, base + j, $urandom);
				end
				2: begin
					for (int j = 0; j < 10; j++)
						push_request(ACT_ADD, $urandom_range(255), random_handle());
				end
				default: begin
					for (int j = 0; j < 10; j++)
						push_request(ACT_GET, $urandom_range(FIRST_SLOT, USABLE - 1),
							$urandom);
				end
			endcase
		end
		total_requests = pending_requests.size();

		// Reset once, released away from the sampling edge.
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait for every request to be taken and every response to arrive.
		while (sent_count < total_requests || expected_responses.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && expected_responses.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
